/* src/cbm_pkg.sv */
// Package for the cartridge bank mapper: write decode codes, the decoded
// operation struct shared by the datapath modules, and fixed constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cbm_pkg;

    // Register regions, taken from address bits 15:12
    localparam logic [3:0] REGION_PRG_LO    = 4'h8;
    localparam logic [3:0] REGION_PRG_HI    = 4'hA;
    localparam logic [3:0] REGION_CHR_FIRST = 4'hB;
    localparam logic [3:0] REGION_CHR_LAST  = 4'hE;
    localparam logic [3:0] REGION_IRQ       = 4'hF;

    // IRQ register select, taken from address bits 3:2
    localparam logic [1:0] IRQ_SEL_LATCH_LO = 2'd0;
    localparam logic [1:0] IRQ_SEL_LATCH_HI = 2'd1;
    localparam logic [1:0] IRQ_SEL_RELOAD   = 2'd2;

    localparam logic [8:0] IRQ_CYCLE     = 9'd257;
    localparam logic [7:0] COUNT_WRAP    = 8'hFF;
    localparam logic [7:0] FIXED_BANK_C  = 8'hFE;
    localparam logic [7:0] FIXED_BANK_E  = 8'hFF;
    localparam logic [7:0] VRAM_BANK_LO  = 8'h06;
    localparam logic [7:0] VRAM_BANK_HI  = 8'h07;
    localparam logic [2:0] SLOT_OFFSET   = 3'd2;
    localparam int         CHR_SLOTS     = 8;

    typedef enum logic [1:0] {
        IRQ_OP_NONE,
        IRQ_OP_LATCH_LO,
        IRQ_OP_LATCH_HI,
        IRQ_OP_RELOAD
    } irq_op_t;

    typedef struct packed {
        logic       prg_lo_we;
        logic       prg_hi_we;
        logic       chr_we;
        logic       chr_hi_nib;
        logic [2:0] chr_slot;
        irq_op_t    irq_op;
        logic       tick;
        logic [7:0] data;
    } cbm_op_t;

    // Character slot from a write address: {a13, a12, a11|a3} + 2, mod 8
    function automatic logic [2:0] chr_slot_of(input logic [15:0] a);
        chr_slot_of = {a[13], a[12], a[11] | a[3]} + SLOT_OFFSET;
    endfunction

endpackage

`default_nettype wire

/* src/cartridge_bank_mapper_with_scanline_irq.sv */
// Top level of the cartridge bank mapper with scanline IRQ.
// Depends on cbm_pkg, cbm_decode, cbm_bank_regs and cbm_irq_ctr.
`timescale 1ns / 1ps
`default_nettype none

// Each input transaction is a CPU register write (cmd 0: addr, wdata) or one
// video cycle tick (cmd 1: line_cycle), and each produces exactly one result
// transaction carrying the full bank mapping and the IRQ line as they stand
// after that item is applied. Writes in 0x8000/0xA000 set the two switchable
// 8K program banks (0xC000 and 0xE000 stay at banks 0xFE and 0xFF); writes
// in 0xB000-0xE000 set one nibble of one of eight 1K character banks; writes
// in 0xF000 load the IRQ latch by nibbles or reload the counter and set the
// enable, each clearing a pending IRQ. While enabled, a tick on cycle 257
// advances the counter; at 0xFF it reloads from the latch and raises irq_out.
// Throughput is one transaction per clock while out_stall does not hold the
// result. A transaction passes one input register, then the decode and
// bank/IRQ update, which land in the mapper state registers that drive the
// result fields directly. in_stall rises only when a transaction waits in
// the input register while the result register is held by out_stall. Reset
// restores the power-on mapping (character slot i = bank i).
module cartridge_bank_mapper_with_scanline_irq (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        cmd,
    input  wire logic [15:0] addr,
    input  wire logic [7:0]  wdata,
    input  wire logic [8:0]  line_cycle,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       prg_bank_lo,
    output logic [7:0]       prg_bank_hi,
    output logic [63:0]      chr_banks,
    output logic [7:0]       vram_slots,
    output logic             irq_out
);
    import cbm_pkg::*;

    // Input register
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        cmd_reg;
    logic [15:0] addr_reg;
    logic [7:0]  wdata_reg;
    logic [8:0]  cycle_reg;

    // Result handshake; the payload is the mapper state itself
    logic        out_valid_reg;
    logic        out_valid_next;

    logic        advance;
    logic        fire;
    logic        take_in;
    cbm_op_t     op;

    // The result slot frees up when empty or taken this cycle
    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (!in_stall)
        begin
            s1_valid_next = in_valid;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture payload only on an accepted transaction
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            cmd_reg   <= cmd;
            addr_reg  <= addr;
            wdata_reg <= wdata;
            cycle_reg <= line_cycle;
        end
    end

    cbm_decode u_decode (
        .cmd        (cmd_reg),
        .addr       (addr_reg),
        .wdata      (wdata_reg),
        .line_cycle (cycle_reg),
        .op         (op)
    );

    // State advances only when the result register takes the new item, so
    // the state registers hold steady while a result is stalled
    cbm_bank_regs u_bank_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (fire),
        .op         (op),
        .prg_lo     (prg_bank_lo),
        .prg_hi     (prg_bank_hi),
        .chr_banks  (chr_banks),
        .vram_slots (vram_slots)
    );

    cbm_irq_ctr u_irq_ctr (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (fire),
        .op    (op),
        .irq   (irq_out)
    );

    assign out_valid = out_valid_reg;

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("Input stalled with no transaction waiting");

    a_fire_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("Processed transaction produced no result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !fire)
        else $error("Mapper state updated while a result was held");

endmodule

`default_nettype wire

/* src/cbm_decode.sv */
// Decode of one registered transaction into a mapper operation.
// Depends on cbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbm_decode (
    input  wire logic            cmd,
    input  wire logic [15:0]     addr,
    input  wire logic [7:0]      wdata,
    input  wire logic [8:0]      line_cycle,
    output cbm_pkg::cbm_op_t     op
);
    import cbm_pkg::*;

    logic [3:0] region;

    assign region = addr[15:12];

    always_comb
    begin
        op            = '0;
        op.irq_op     = IRQ_OP_NONE;
        op.data       = wdata;
        op.chr_slot   = chr_slot_of(addr);
        op.chr_hi_nib = addr[2];
        if (cmd)
        begin
            op.tick = (line_cycle == IRQ_CYCLE);
        end
        else if (region == REGION_PRG_LO)
        begin
            op.prg_lo_we = 1'b1;
        end
        else if (region == REGION_PRG_HI)
        begin
            op.prg_hi_we = 1'b1;
        end
        else if (region inside {[REGION_CHR_FIRST:REGION_CHR_LAST]})
        begin
            op.chr_we = 1'b1;
        end
        else if (region == REGION_IRQ)
        begin
            case (addr[3:2])
                IRQ_SEL_LATCH_LO: op.irq_op = IRQ_OP_LATCH_LO;
                IRQ_SEL_LATCH_HI: op.irq_op = IRQ_OP_LATCH_HI;
                IRQ_SEL_RELOAD:   op.irq_op = IRQ_OP_RELOAD;
                default:          op.irq_op = IRQ_OP_NONE;
            endcase
        end
    end

endmodule

`default_nettype wire

/* src/cbm_bank_regs.sv */
// Program and character bank registers, updated by decoded writes.
// Depends on cbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbm_bank_regs (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire cbm_pkg::cbm_op_t op,
    output logic [7:0]            prg_lo,
    output logic [7:0]            prg_hi,
    output logic [63:0]           chr_banks,
    output logic [7:0]            vram_slots
);
    import cbm_pkg::*;

    logic [7:0] prg_lo_reg;
    logic [7:0] prg_hi_reg;
    logic [7:0] chr_reg [CHR_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_lo_reg <= '0;
            prg_hi_reg <= '0;
        end
        else if (en)
        begin
            if (op.prg_lo_we)
            begin
                prg_lo_reg <= op.data;
            end
            if (op.prg_hi_we)
            begin
                prg_hi_reg <= op.data;
            end
        end
    end

    for (genvar i = 0; i < CHR_SLOTS; i++)
    begin : g_chr
        logic [7:0] chr_next;

        // Merge the written nibble into the addressed half
        always_comb
        begin
            chr_next = chr_reg[i];
            if (op.chr_hi_nib)
            begin
                chr_next[7:4] = op.data[3:0];
            end
            else
            begin
                chr_next[3:0] = op.data[3:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                chr_reg[i] <= 8'(i);
            end
            else if (en && op.chr_we && (op.chr_slot == 3'(i)))
            begin
                chr_reg[i] <= chr_next;
            end
        end

        assign chr_banks[8*i +: 8] = chr_reg[i];
        assign vram_slots[i]       = (chr_reg[i] == VRAM_BANK_LO) ||
                                     (chr_reg[i] == VRAM_BANK_HI);
    end

    assign prg_lo = prg_lo_reg;
    assign prg_hi = prg_hi_reg;

endmodule

`default_nettype wire

/* src/cbm_irq_ctr.sv */
// Scanline IRQ counter: latch, count, enable and pending line.
// Depends on cbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbm_irq_ctr (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire cbm_pkg::cbm_op_t op,
    output logic                  irq
);
    import cbm_pkg::*;

    logic [7:0] latch_reg;
    logic [7:0] latch_next;
    logic [7:0] count_reg;
    logic [7:0] count_next;
    logic       enable_reg;
    logic       enable_next;
    logic       pending_reg;
    logic       pending_next;

    always_comb
    begin
        latch_next   = latch_reg;
        count_next   = count_reg;
        enable_next  = enable_reg;
        pending_next = pending_reg;
        case (op.irq_op)
            IRQ_OP_LATCH_LO:
            begin
                latch_next[3:0] = op.data[3:0];
                pending_next    = 1'b0;
            end
            IRQ_OP_LATCH_HI:
            begin
                latch_next[7:4] = op.data[3:0];
                pending_next    = 1'b0;
            end
            IRQ_OP_RELOAD:
            begin
                count_next   = latch_reg;
                enable_next  = op.data[1];
                pending_next = 1'b0;
            end
            default:
            begin
                if (op.tick && enable_reg)
                begin
                    // Wrap: reload from the latch and raise the line
                    if (count_reg == COUNT_WRAP)
                    begin
                        count_next   = latch_reg;
                        pending_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + 8'd1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg   <= '0;
            count_reg   <= '0;
            enable_reg  <= 1'b0;
            pending_reg <= 1'b0;
        end
        else if (en)
        begin
            latch_reg   <= latch_next;
            count_reg   <= count_next;
            enable_reg  <= enable_next;
            pending_reg <= pending_next;
        end
    end

    assign irq = pending_reg;

    a_reload_clears: assert property (@(posedge clk) disable iff (!rst_n)
        en && (op.irq_op == IRQ_OP_RELOAD) |=> !pending_reg)
        else $error("IRQ reload did not clear the pending line");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(count_reg) && $stable(pending_reg) && $stable(latch_reg))
        else $error("IRQ state changed without a transaction");

    a_wrap_raises: assert property (@(posedge clk) disable iff (!rst_n)
        en && (op.irq_op == IRQ_OP_NONE) && op.tick && enable_reg &&
        (count_reg == COUNT_WRAP)
        |=> pending_reg && (count_reg == $past(latch_reg)))
        else $error("Counter wrap did not reload and raise the IRQ");

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for cartridge_bank_mapper_with_scanline_irq: drives CPU
// writes and video ticks, predicts every mapping transaction, checks each field.
// Depends on cbm_pkg and the mapper RTL under src.
`timescale 1ns / 1ps

module tb_top;

    import cbm_pkg::*;

    // Input kinds carried on cmd
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Abort when this many cycles pass with no transaction on either side
    localparam int WATCHDOG_LIMIT = 1000;
    // Receiver hold-off length for the backpressure stretch
    localparam int HOLD_CYCLES    = 80;
    // Cap on printed mismatch lines; every mismatch is still counted
    localparam int PRINT_CAP      = 100;

    // Everything the mapper reports after one transaction
    typedef struct packed {
        logic [7:0]  prg_lo;
        logic [7:0]  prg_hi;
        logic [63:0] chr;
        logic [7:0]  vram;
        logic        irq;
    } mapping_t;

    // One pending bus transaction plus the pacing that goes with it
    typedef struct {
        logic        cmd;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic [8:0]  cyc;
        int          src_idle;
        int          snk_stall;
        bit          drain_first;
        bit          hold_sink;
    } bus_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        cmd = CMD_WRITE;
    logic [15:0] addr = 16'h0000;
    logic [7:0]  wdata = 8'h00;
    logic [8:0]  line_cycle = 9'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  prg_bank_lo;
    logic [7:0]  prg_bank_hi;
    logic [63:0] chr_banks;
    logic [7:0]  vram_slots;
    logic        irq_out;

    cartridge_bank_mapper_with_scanline_irq dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .addr       (addr),
        .wdata      (wdata),
        .line_cycle (line_cycle),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .prg_bank_lo(prg_bank_lo),
        .prg_bank_hi(prg_bank_hi),
        .chr_banks  (chr_banks),
        .vram_slots (vram_slots),
        .irq_out    (irq_out)
    );

    // Predicted mapper state
    logic [7:0] prg_lo_q;
    logic [7:0] prg_hi_q;
    logic [7:0] chr_q [8];
    logic [7:0] latch_q;
    logic [7:0] count_q;
    logic       irq_en_q;
    logic       irq_pend_q;

    bus_item_t pending_items[$];   // stimulus not yet offered to the block
    mapping_t  mapping_due[$];     // predicted mappings, oldest first

    // Pacing applied to transactions as they are queued
    int cur_src_idle  = 0;
    int cur_snk_stall = 0;
    bit next_drain    = 1'b0;
    bit next_hold     = 1'b0;

    // Shared between the driver, the receiver and the monitors
    int snk_pct     = 0;
    int hold_req    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    bit in_took     = 1'b0;
    int mismatches  = 0;
    int idle_cycles = 0;

    initial begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Mapper prediction: apply one accepted transaction to the predicted
    // state and queue the mapping the block must report for it.
    // ------------------------------------------------------------------
    task automatic predict_mapping(input logic c, input logic [15:0] a,
                                   input logic [7:0] d, input logic [8:0] lc);
        logic [3:0] region;
        logic [2:0] slot;
        mapping_t   m;
        region = a[15:12];
        if (c == CMD_WRITE) begin
            if (region == REGION_PRG_LO) begin
                prg_lo_q = d;
            end
            else if (region == REGION_PRG_HI) begin
                prg_hi_q = d;
            end
            else if (region >= REGION_CHR_FIRST && region <= REGION_CHR_LAST) begin
                // Slot comes from a13, a12 and (a11 or a3), offset by two
                slot = 3'((((a >> 8) | (a & 16'h0008)) >> 3) + 16'd2);
                if (a[2])
                    chr_q[slot][7:4] = d[3:0];
                else
                    chr_q[slot][3:0] = d[3:0];
            end
            else if (region == REGION_IRQ) begin
                case (a[3:2])
                    IRQ_SEL_LATCH_LO:
                    begin
                        latch_q[3:0] = d[3:0];
                        irq_pend_q = 1'b0;
                    end
                    IRQ_SEL_LATCH_HI:
                    begin
                        latch_q[7:4] = d[3:0];
                        irq_pend_q = 1'b0;
                    end
                    IRQ_SEL_RELOAD:
                    begin
                        count_q = latch_q;
                        irq_en_q = d[1];
                        irq_pend_q = 1'b0;
                    end
                    default:
                    begin
                        // unused register: drop the write
                    end
                endcase
            end
            // 0x9000 range and addresses below 0x8000: drop
        end
        else if (irq_en_q && lc == IRQ_CYCLE) begin
            // At the wrap value reload instead of incrementing
            if (count_q == COUNT_WRAP) begin
                count_q = latch_q;
                irq_pend_q = 1'b1;
            end
            else begin
                count_q = count_q + 8'd1;
            end
        end
        m.prg_lo = prg_lo_q;
        m.prg_hi = prg_hi_q;
        for (int i = 0; i < CHR_SLOTS; i++) begin
            m.chr[8*i +: 8] = chr_q[i];
            m.vram[i] = (chr_q[i] == VRAM_BANK_LO) || (chr_q[i] == VRAM_BANK_HI);
        end
        m.irq = irq_pend_q;
        mapping_due.push_back(m);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PRINT_CAP)
            $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    task automatic enqueue(input bus_item_t it);
        it.src_idle    = cur_src_idle;
        it.snk_stall   = cur_snk_stall;
        it.drain_first = next_drain;
        it.hold_sink   = next_hold;
        next_drain     = 1'b0;
        next_hold      = 1'b0;
        pending_items.push_back(it);
    endtask

    // Unused fields get random content so every input bit toggles
    task automatic queue_write(input logic [15:0] a, input logic [7:0] d);
        bus_item_t it;
        it.cmd   = CMD_WRITE;
        it.addr  = a;
        it.wdata = d;
        it.cyc   = 9'($urandom_range(0, 340));
        enqueue(it);
    endtask

    task automatic queue_tick(input logic [8:0] lc);
        bus_item_t it;
        it.cmd   = CMD_TICK;
        it.addr  = 16'($urandom);
        it.wdata = 8'($urandom);
        it.cyc   = lc;
        enqueue(it);
    endtask

    // Weighted mix: many ticks on the counting cycle, latch values biased
    // high so the counter wraps often, plus noise writes anywhere.
    task automatic queue_random();
        int          r;
        logic [15:0] a;
        logic [7:0]  d;
        r = $urandom_range(0, 99);
        d = 8'($urandom);
        if (r < 40) begin
            if ($urandom_range(0, 2) != 0)
                queue_tick(IRQ_CYCLE);
            else
                queue_tick(9'($urandom_range(0, 340)));
        end
        else if (r < 52) begin
            a = {($urandom_range(0, 1) != 0) ? REGION_PRG_HI : REGION_PRG_LO,
                 12'($urandom)};
            queue_write(a, d);
        end
        else if (r < 75) begin
            a = {4'($urandom_range(REGION_CHR_FIRST, REGION_CHR_LAST)), 12'($urandom)};
            // Steer some character banks onto the VRAM pages
            if ($urandom_range(0, 3) == 0)
                d[3:0] = a[2] ? 4'h0 : 4'($urandom_range(6, 7));
            queue_write(a, d);
        end
        else if (r < 92) begin
            a = {REGION_IRQ, 12'($urandom)};
            if (a[3:2] == IRQ_SEL_LATCH_HI && $urandom_range(0, 3) != 0)
                d[3:0] = 4'hF;
            if (a[3:2] == IRQ_SEL_RELOAD && $urandom_range(0, 4) != 0)
                d[1] = 1'b1;
            queue_write(a, d);
        end
        else begin
            queue_write(16'($urandom), d);
        end
    endtask

    // ------------------------------------------------------------------
    // Input acceptance: predict on every accepted transaction and tell
    // the driver it may advance.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_took <= 1'b0;
        end
        else begin
            in_took <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                predict_mapping(cmd, addr, wdata, line_cycle);
        end
    end

    // Driver: change inputs on the falling edge; hold the payload while
    // stalled, and only advance once the current transaction was taken.
    always @(negedge clk) begin
        bus_item_t it;
        if (rst_n && (!in_valid || in_took)) begin
            if (pending_items.size() == 0) begin
                in_valid <= 1'b0;
            end
            else begin
                it = pending_items[0];
                if (it.drain_first && mapping_due.size() != 0) begin
                    in_valid <= 1'b0;
                end
                else if ($urandom_range(0, 99) < it.src_idle) begin
                    in_valid <= 1'b0;
                end
                else begin
                    void'(pending_items.pop_front());
                    cmd        <= it.cmd;
                    addr       <= it.addr;
                    wdata      <= it.wdata;
                    line_cycle <= it.cyc;
                    in_valid   <= 1'b1;
                    snk_pct    <= it.snk_stall;
                    if (it.hold_sink)
                        hold_req <= hold_req + 1;
                end
            end
        end
    end

    // Receiver: random stalls at the current rate, or a long hold-off when
    // the driver asks for one so the pipeline backs up into in_stall.
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_req != hold_seen) begin
                hold_seen <= hold_req;
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else begin
                out_stall <= ($urandom_range(0, 99) < snk_pct);
            end
        end
    end

    // Result monitor: compare each accepted result with the oldest prediction
    always @(posedge clk) begin
        mapping_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (mapping_due.size() == 0) begin
                report_mismatch("result with nothing expected", 64'd0, 64'd0);
            end
            else begin
                want = mapping_due.pop_front();
                if (prg_bank_lo !== want.prg_lo)
                    report_mismatch("prg_bank_lo", 64'(prg_bank_lo), 64'(want.prg_lo));
                if (prg_bank_hi !== want.prg_hi)
                    report_mismatch("prg_bank_hi", 64'(prg_bank_hi), 64'(want.prg_hi));
                if (chr_banks !== want.chr)
                    report_mismatch("chr_banks", chr_banks, want.chr);
                if (vram_slots !== want.vram)
                    report_mismatch("vram_slots", 64'(vram_slots), 64'(want.vram));
                if (irq_out !== want.irq)
                    report_mismatch("irq_out", 64'(irq_out), 64'(want.irq));
            end
        end
    end

    // Watchdog: count cycles in which no transaction moves on either side
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed transactions, then random phases with
    // different idling, then drain and finish.
    // ------------------------------------------------------------------
    initial begin
        // Power-on mapping: character slot i holds bank i
        prg_lo_q   = 8'h00;
        prg_hi_q   = 8'h00;
        latch_q    = 8'h00;
        count_q    = 8'h00;
        irq_en_q   = 1'b0;
        irq_pend_q = 1'b0;
        for (int i = 0; i < CHR_SLOTS; i++)
            chr_q[i] = 8'(i);

        // Directed part, no idling
        queue_tick(9'd0);                 // reset mapping as it stands
        queue_write(16'h8000, 8'hFF);
        queue_write(16'h8ABC, 8'h00);
        queue_write(16'hAFFF, 8'hFF);
        queue_write(16'h9000, 8'h77);     // unmapped range: ignored
        // One write per character slot, both nibbles, some onto VRAM pages
        queue_write(16'hB000, 8'hF6);
        queue_write(16'hB00C, 8'hAF);
        queue_write(16'hC800, 8'h07);
        queue_write(16'hC004, 8'h0F);
        queue_write(16'hD008, 8'h00);
        queue_write(16'hD004, 8'h3C);
        queue_write(16'hEFFF, 8'hFF);
        queue_write(16'hE000, 8'h06);
        queue_write(16'hF00C, 8'hFF);     // unused IRQ register: ignored
        queue_write(16'hF000, 8'h0E);     // latch 0xFE
        queue_write(16'hF004, 8'hFF);
        queue_write(16'hF008, 8'h02);     // reload and enable
        queue_tick(9'd256);
        queue_tick(IRQ_CYCLE);            // count reaches 0xFF
        queue_tick(9'd258);
        queue_tick(IRQ_CYCLE);            // wrap: reload from latch, raise IRQ
        queue_tick(9'd340);
        queue_write(16'hF000, 8'h00);     // latch write clears IRQ
        queue_write(16'hF008, 8'h00);     // reload with enable off
        queue_tick(IRQ_CYCLE);            // disabled: no count

        repeat (150) queue_random();
        // Long receiver hold-off while the sender keeps offering
        next_hold = 1'b1;
        repeat (40) queue_random();
        repeat (150) queue_random();

        // Sender idling; pause until the block drains first
        cur_src_idle = 54;
        next_drain = 1'b1;
        repeat (300) queue_random();

        // Receiver stalling
        cur_src_idle = 0;
        cur_snk_stall = 54;
        next_drain = 1'b1;
        repeat (300) queue_random();

        // Both sides
        cur_src_idle = 17;
        cur_snk_stall = 17;
        next_drain = 1'b1;
        repeat (300) queue_random();

        // Closing stretch at full rate
        cur_src_idle = 0;
        cur_snk_stall = 0;
        repeat (60) queue_random();

        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Wait for all stimulus to go in, then for every prediction to match
        while (pending_items.size() != 0 || in_valid)
            @(posedge clk);
        while (mapping_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0 && mapping_due.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

/* cartridge_bank_mapper_with_scanline_irq.f */
src/cbm_pkg.sv
src/cbm_decode.sv
src/cbm_bank_regs.sv
src/cbm_irq_ctr.sv
src/cartridge_bank_mapper_with_scanline_irq.sv
bench/tb_top.sv
